@@ rtl/demand_paged_byte_memory_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the demand paged byte memory
// Shared forms for the concurrent checks of the demand_paged_byte_memory module.
// ----------------------------------------------------------------------------
`ifndef DEMAND_PAGED_BYTE_MEMORY_ASSERT_SVH
`define DEMAND_PAGED_BYTE_MEMORY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPBM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DPBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dpbm_pkg.sv @@
// ----------------------------------------------------------------------------
// dpbm_pkg
// Constants, status codes and the control store of the page table walker.
// ----------------------------------------------------------------------------
package dpbm_pkg;

  // Address split: four 9-bit table indices above a 12-bit page offset.
  localparam int IDX_W       = 9;
  localparam int OFF_W       = 12;
  localparam int VADDR_W     = 48;
  localparam int ENTRIES     = 512;
  localparam int FRAME_BYTES = 4096;
  localparam int LEVELS      = 4;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAULT   = 2'd1;
  localparam logic [1:0] ST_NOSPACE = 2'd2;

  // Step counter width and step addresses of the control program.
  localparam int UPC_W = 4;
  localparam logic [UPC_W-1:0] U_IDLE   = 4'd0;
  localparam logic [UPC_W-1:0] U_NRD    = 4'd1;
  localparam logic [UPC_W-1:0] U_CHK    = 4'd2;
  localparam logic [UPC_W-1:0] U_DEC    = 4'd3;
  localparam logic [UPC_W-1:0] U_RCHK   = 4'd4;
  localparam logic [UPC_W-1:0] U_PRD    = 4'd5;
  localparam logic [UPC_W-1:0] U_WCHK   = 4'd6;
  localparam logic [UPC_W-1:0] U_LCHK   = 4'd7;
  localparam logic [UPC_W-1:0] U_ALLOC  = 4'd8;
  localparam logic [UPC_W-1:0] U_FCHK   = 4'd9;
  localparam logic [UPC_W-1:0] U_FRAME  = 4'd10;
  localparam logic [UPC_W-1:0] U_WPAGE  = 4'd11;
  localparam logic [UPC_W-1:0] U_FAULT  = 4'd12;
  localparam logic [UPC_W-1:0] U_CAP    = 4'd13;
  localparam logic [UPC_W-1:0] U_OOS    = 4'd14;
  localparam logic [UPC_W-1:0] U_EMIT   = 4'd15;

  // Datapath action of one step.
  typedef enum logic [3:0] {
    A_NONE,
    A_LATCH,
    A_NODE_RD,
    A_WALK,
    A_PAGE_RD,
    A_CAP,
    A_FAULT,
    A_OOS,
    A_ALLOC,
    A_FRAME,
    A_WPAGE,
    A_EMIT
  } act_e;

  // Jump condition of one step.
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_ACC,
    C_DESCEND,
    C_WRITE,
    C_FE_ZERO,
    C_NOROOM,
    C_LVL3,
    C_ALLOC_MORE,
    C_OUT_FREE
  } cond_e;

  // One control word: action, jump condition, its polarity and the target.
  typedef struct packed {
    act_e             act;
    cond_e            cond;
    logic             neg;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  // Control store. A step jumps to its target when the condition (inverted
  // if neg is set) holds, and otherwise falls through to the next step.
  function automatic ctrl_t upc_rom(input logic [UPC_W-1:0] upc);
    ctrl_t w;
    w = '{act: A_NONE, cond: C_ALWAYS, neg: 1'b0, target: U_IDLE};
    unique case (upc)
      U_IDLE:  w = '{act: A_LATCH,   cond: C_IN_ACC,     neg: 1'b1, target: U_IDLE};
      U_NRD:   w = '{act: A_NODE_RD, cond: C_ALWAYS,     neg: 1'b0, target: U_CHK};
      U_CHK:   w = '{act: A_WALK,    cond: C_DESCEND,    neg: 1'b0, target: U_NRD};
      U_DEC:   w = '{act: A_NONE,    cond: C_WRITE,      neg: 1'b0, target: U_WCHK};
      U_RCHK:  w = '{act: A_NONE,    cond: C_FE_ZERO,    neg: 1'b0, target: U_FAULT};
      U_PRD:   w = '{act: A_PAGE_RD, cond: C_ALWAYS,     neg: 1'b0, target: U_CAP};
      U_WCHK:  w = '{act: A_NONE,    cond: C_NOROOM,     neg: 1'b0, target: U_OOS};
      U_LCHK:  w = '{act: A_NONE,    cond: C_LVL3,       neg: 1'b0, target: U_FCHK};
      U_ALLOC: w = '{act: A_ALLOC,   cond: C_ALLOC_MORE, neg: 1'b0, target: U_ALLOC};
      U_FCHK:  w = '{act: A_NONE,    cond: C_FE_ZERO,    neg: 1'b1, target: U_WPAGE};
      U_FRAME: w = '{act: A_FRAME,   cond: C_ALWAYS,     neg: 1'b0, target: U_WPAGE};
      U_WPAGE: w = '{act: A_WPAGE,   cond: C_ALWAYS,     neg: 1'b0, target: U_EMIT};
      U_FAULT: w = '{act: A_FAULT,   cond: C_ALWAYS,     neg: 1'b0, target: U_EMIT};
      U_CAP:   w = '{act: A_CAP,     cond: C_ALWAYS,     neg: 1'b0, target: U_EMIT};
      U_OOS:   w = '{act: A_OOS,     cond: C_ALWAYS,     neg: 1'b0, target: U_EMIT};
      // Waits here while the output holds an untaken result; the fall-through
      // wraps the step counter back to the idle step.
      U_EMIT:  w = '{act: A_EMIT,    cond: C_OUT_FREE,   neg: 1'b1, target: U_EMIT};
    endcase
    return w;
  endfunction

endpackage

@@ rtl/demand_paged_byte_memory.sv @@
// ----------------------------------------------------------------------------
// demand_paged_byte_memory
// Sparse byte memory behind a four-level radix page table with allocation on
// write, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_axis channel is a byte read (tuser 0) or a byte
//   write (tuser 1) to a 48-bit virtual address. Each request gives exactly
//   one result on the m_axis channel: the byte in tdata and a status in tuser
//   (ok, unmapped read fault, or write dropped because the node or frame pool
//   is exhausted).
//   One request is worked on at a time. A result is registered at the end of
//   a sequence of steps: the walk reads each table level on the single node
//   memory port (address, then registered data), then come decision steps, an
//   allocation step per missing node, a frame entry step for an unmapped page
//   and the data access on the page memory port. The next request is accepted
//   once the sequence is back in its idle step.
//   A result waits in the output register until taken; a new request is
//   accepted meanwhile, and its sequence holds in its last step while the
//   output register is still full.
//   After reset both memories are cleared one entry per cycle; no request is
//   accepted until the clearing pass has finished.
// ----------------------------------------------------------------------------
`include "demand_paged_byte_memory_assert.svh"

module demand_paged_byte_memory
  import dpbm_pkg::*;
#(
  parameter int NODE_COUNT  = 64,
  parameter int FRAME_COUNT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // vaddr [47:0], write_data [55:48]
  input  logic [0:0]  s_axis_tuser,   // req_type [0]
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // read_data [7:0]
  output logic [1:0]  m_axis_tuser    // status [1:0]
);

  // Derived sizes.
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int NODE_DEPTH = NODE_COUNT * ENTRIES;
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int PAGE_DEPTH = FRAME_COUNT * FRAME_BYTES;
  localparam int PAGE_AW    = $clog2(PAGE_DEPTH);
  localparam int FRM_W      = $clog2(FRAME_COUNT + 1);
  localparam int ENTRY_W    = (NODE_W > FRM_W) ? NODE_W : FRM_W;
  localparam int NFN_W      = $clog2(NODE_COUNT + 1);
  localparam int CLR_DEPTH  = (NODE_DEPTH > PAGE_DEPTH) ? NODE_DEPTH : PAGE_DEPTH;
  localparam int CLR_W      = $clog2(CLR_DEPTH);

  // Sequencer and request registers.
  logic [UPC_W-1:0]   upc_q, upc_d;
  ctrl_t              ctrl;
  logic               type_q;
  logic [VADDR_W-1:0] vaddr_q;
  logic [7:0]         wdata_q;
  logic [NODE_W-1:0]  node_q;
  logic [1:0]         level_q;
  logic [ENTRY_W-1:0] fe_q;
  logic [NFN_W-1:0]   nfn_q;
  logic [FRM_W-1:0]   nff_q;
  logic [7:0]         res_data_q;
  logic [1:0]         res_status_q;
  logic               m_valid_q;
  logic [7:0]         m_data_q;
  logic [1:0]         m_status_q;
  logic               clr_busy_q;
  logic [CLR_W-1:0]   clr_cnt_q;

  // Memory ports.
  logic               node_we, node_re;
  logic [NODE_AW-1:0] node_addr;
  logic [ENTRY_W-1:0] node_wdata, node_rdata;
  logic               page_we, page_re;
  logic [PAGE_AW-1:0] pmem_addr;
  logic [7:0]         page_wdata, page_rdata;

  // Datapath helpers.
  logic [IDX_W-1:0]   cur_idx;
  logic [ENTRY_W-1:0] frame_idx;
  logic [1:0]         need_nodes;
  logic               in_acc, out_free, descend, noroom, cond_val;

  assign ctrl   = upc_rom(upc_q);
  assign in_acc = s_axis_tvalid & s_axis_tready;

  // Table index of the current level, root level in the top bits.
  assign cur_idx   = vaddr_q[OFF_W + (2'd3 - level_q) * IDX_W +: IDX_W];
  assign frame_idx = fe_q - ENTRY_W'(1);

  // Jump conditions.
  assign out_free   = !m_valid_q || m_axis_tready;
  assign descend    = (level_q != 2'd3) && (node_rdata != '0);
  assign need_nodes = 2'd3 - level_q;
  assign noroom     = (({1'b0, nfn_q} + (NFN_W + 1)'(need_nodes)) > (NFN_W + 1)'(NODE_COUNT))
                   || ((fe_q == '0) && (nff_q >= FRM_W'(FRAME_COUNT)));

  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS:     cond_val = 1'b1;
      C_IN_ACC:     cond_val = in_acc;
      C_DESCEND:    cond_val = descend;
      C_WRITE:      cond_val = type_q;
      C_FE_ZERO:    cond_val = (fe_q == '0);
      C_NOROOM:     cond_val = noroom;
      C_LVL3:       cond_val = (level_q == 2'd3);
      C_ALLOC_MORE: cond_val = (level_q != 2'd2);
      C_OUT_FREE:   cond_val = out_free;
      default:      cond_val = 1'b0;
    endcase
  end

  // Next step: jump or fall through.
  assign upc_d = (cond_val ^ ctrl.neg) ? ctrl.target : upc_q + UPC_W'(1);

  // Memory port control; the clearing pass owns both ports after reset.
  always_comb begin
    node_we    = 1'b0;
    node_re    = 1'b0;
    node_addr  = NODE_AW'({node_q, cur_idx});
    node_wdata = '0;
    page_we    = 1'b0;
    page_re    = 1'b0;
    pmem_addr  = PAGE_AW'({frame_idx, vaddr_q[OFF_W-1:0]});
    page_wdata = wdata_q;
    if (clr_busy_q) begin
      node_we    = ({1'b0, clr_cnt_q} < (CLR_W + 1)'(NODE_DEPTH));
      node_addr  = NODE_AW'(clr_cnt_q);
      page_we    = ({1'b0, clr_cnt_q} < (CLR_W + 1)'(PAGE_DEPTH));
      pmem_addr  = PAGE_AW'(clr_cnt_q);
      page_wdata = '0;
    end else begin
      unique case (ctrl.act)
        A_NODE_RD: node_re = 1'b1;
        A_ALLOC: begin
          node_we    = 1'b1;
          node_wdata = ENTRY_W'(nfn_q);
        end
        A_FRAME: begin
          node_we    = 1'b1;
          node_wdata = ENTRY_W'(nff_q) + ENTRY_W'(1);
        end
        A_PAGE_RD: page_re = 1'b1;
        A_WPAGE:   page_we = 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Control registers: step counter, level, pools, clearing pass, output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q      <= U_IDLE;
      level_q    <= '0;
      nfn_q      <= NFN_W'(1);
      nff_q      <= '0;
      m_valid_q  <= 1'b0;
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + CLR_W'(1);
        if (clr_cnt_q == CLR_W'(CLR_DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end else begin
        upc_q <= upc_d;
      end
      // A taken result frees the output unless the next one moves in now.
      if (m_valid_q && m_axis_tready && !((ctrl.act == A_EMIT) && out_free)) begin
        m_valid_q <= 1'b0;
      end
      unique case (ctrl.act)
        A_LATCH: begin
          if (in_acc) begin
            level_q <= '0;
          end
        end
        A_WALK: begin
          if (descend) begin
            level_q <= level_q + 2'd1;
          end
        end
        A_ALLOC: begin
          nfn_q   <= nfn_q + NFN_W'(1);
          level_q <= level_q + 2'd1;
        end
        A_FRAME: nff_q <= nff_q + FRM_W'(1);
        A_EMIT: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    unique case (ctrl.act)
      A_LATCH: begin
        if (in_acc) begin
          type_q  <= s_axis_tuser[0];
          vaddr_q <= s_axis_tdata[VADDR_W-1:0];
          wdata_q <= s_axis_tdata[VADDR_W +: 8];
          node_q  <= '0;
        end
      end
      A_WALK: begin
        if (descend) begin
          node_q <= NODE_W'(node_rdata);
        end else if (level_q == 2'd3) begin
          fe_q <= node_rdata;
        end else begin
          fe_q <= '0;
        end
      end
      A_ALLOC: node_q <= NODE_W'(nfn_q);
      A_FRAME: fe_q <= ENTRY_W'(nff_q) + ENTRY_W'(1);
      A_CAP: begin
        res_data_q   <= page_rdata;
        res_status_q <= ST_OK;
      end
      A_FAULT: begin
        res_data_q   <= '0;
        res_status_q <= ST_FAULT;
      end
      A_OOS: begin
        res_data_q   <= '0;
        res_status_q <= ST_NOSPACE;
      end
      A_WPAGE: begin
        res_data_q   <= '0;
        res_status_q <= ST_OK;
      end
      A_EMIT: begin
        if (out_free) begin
          m_data_q   <= res_data_q;
          m_status_q <= res_status_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Table node store: child node numbers, or frame number plus one at the
  // last level; zero marks a missing entry.
  dpbm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODE_DEPTH)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .re_i    (node_re),
    .addr_i  (node_addr),
    .wdata_i (node_wdata),
    .rdata_o (node_rdata)
  );

  // Data frame store.
  dpbm_ram #(
    .WIDTH (8),
    .DEPTH (PAGE_DEPTH)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (page_we),
    .re_i    (page_re),
    .addr_i  (pmem_addr),
    .wdata_i (page_wdata),
    .rdata_o (page_rdata)
  );

  assign s_axis_tready = (upc_q == U_IDLE) && !clr_busy_q;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_status_q;

  // Checks.
  `DPBM_ASSERT_SAME(a_no_req_in_clear, clk_i, rst_ni, clr_busy_q, !s_axis_tready,
                    "request accepted during the clearing pass")
  `DPBM_ASSERT_SAME(a_node_pool, clk_i, rst_ni, upc_q == U_ALLOC && !clr_busy_q,
                    nfn_q < NFN_W'(NODE_COUNT), "node allocated from an empty pool")
  `DPBM_ASSERT_SAME(a_frame_pool, clk_i, rst_ni, upc_q == U_FRAME && !clr_busy_q,
                    nff_q < FRM_W'(FRAME_COUNT), "frame allocated from an empty pool")
  `DPBM_ASSERT_NEXT(a_emit_hold, clk_i, rst_ni,
                    upc_q == U_EMIT && !clr_busy_q && m_valid_q && !m_axis_tready,
                    upc_q == U_EMIT, "result step left while the output is stalled")
  `DPBM_ASSERT_SAME(a_fault_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser != ST_OK,
                    m_axis_tdata == 8'd0, "fault or dropped write with nonzero data")

endmodule

@@ rtl/dpbm_ram.sv @@
// ----------------------------------------------------------------------------
// dpbm_ram
// Generic single-port RAM with one write and one read per cycle on a shared address, and registered read.
// ----------------------------------------------------------------------------
module dpbm_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array and read register.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the demand paged byte memory
// Drives byte read and write requests through the four-level page table walk
// and checks every result against a behavioral copy of the walker or a typed
// expectation of a directed request. A short table of directed requests is
// followed by random traffic. The random traffic mostly hits a small set of
// hot pages and also sends fully random addresses, which run the node and
// frame pools dry. Both channels idle at random, and the result side holds
// off once long enough to back up the request channel.
// ----------------------------------------------------------------------------
module tb
  import dpbm_pkg::*;
();

  localparam int NODE_COUNT       = 64;
  localparam int FRAME_COUNT      = 64;
  localparam int TOTAL_REQUESTS   = 1500;
  localparam int DIRECTED_ROWS    = 22;
  localparam int HOLD_AFTER       = 600;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 32;
  // The clearing pass after reset runs with no handshake.
  localparam int WATCHDOG_LIMIT   = 1000000;

  typedef struct packed {
    logic        wr;
    logic [47:0] va;
    logic [7:0]  wd;
  } req_t;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    req_t    req;
    logic    typed;
    result_t want;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata;   // vaddr [47:0], write_data [55:48]
  logic [0:0]  s_axis_tuser;   // req_type [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // read_data [7:0]
  logic [1:0]  m_axis_tuser;   // status [1:0]

  // Shadow of the page tables and data frames.
  int unsigned page_table [int unsigned];
  logic [7:0]  frame_bytes [int unsigned];
  int unsigned next_node;
  int unsigned frames_used;

  result_t     pending_results [$];
  int unsigned errors = 0;
  int unsigned results_taken = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_calm;
  int unsigned recv_calm = 0;
  int unsigned read_hits, read_faults, writes_stored, writes_dropped;

  // Hot address pieces that the random traffic keeps coming back to.
  logic [8:0]  hot_l0 [3];
  logic [8:0]  hot_l1 [2];
  logic [8:0]  hot_l2 [2];
  logic [8:0]  hot_l3 [16];
  logic [11:0] hot_off [8];

  stim_row_t   directed_rows [DIRECTED_ROWS];

  demand_paged_byte_memory #(
    .NODE_COUNT (NODE_COUNT),
    .FRAME_COUNT(FRAME_COUNT)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Table entry of a node; zero means the entry is not present.
  function automatic int unsigned entry_of(input int unsigned node, input int unsigned ix);
    int unsigned key;
    key = node * ENTRIES + ix;
    return page_table.exists(key) ? page_table[key] : 0;
  endfunction

  // Walks the shadow tables for one request, allocates on a write, and
  // returns the result the block must give.
  function automatic result_t walk_and_access(input req_t r);
    result_t     res;
    int unsigned ix [4];
    int unsigned offs, node, lvl, leaf, need_nodes, key;
    logic        need_frame;
    ix[0] = r.va[47:39];
    ix[1] = r.va[38:30];
    ix[2] = r.va[29:21];
    ix[3] = r.va[20:12];
    offs  = r.va[11:0];
    node  = 0;
    lvl   = 0;
    leaf  = 0;
    res.data   = 8'h00;
    res.status = ST_OK;
    while (lvl < 3 && entry_of(node, ix[lvl]) != 0) begin
      node = entry_of(node, ix[lvl]);
      lvl++;
    end
    if (lvl == 3) leaf = entry_of(node, ix[3]);
    // A read never changes state.
    if (!r.wr) begin
      if (leaf == 0) begin
        res.status = ST_FAULT;
        read_faults++;
      end else begin
        key = (leaf - 1) * FRAME_BYTES + offs;
        res.data = frame_bytes.exists(key) ? frame_bytes[key] : 8'h00;
        read_hits++;
      end
      return res;
    end
    // A write first checks that the pools can cover everything it needs.
    need_nodes = 3 - lvl;
    need_frame = (leaf == 0);
    if (next_node + need_nodes > NODE_COUNT || (need_frame && frames_used >= FRAME_COUNT)) begin
      res.status = ST_NOSPACE;
      writes_dropped++;
      return res;
    end
    while (lvl < 3) begin
      page_table[node * ENTRIES + ix[lvl]] = next_node;
      node = next_node;
      next_node++;
      lvl++;
    end
    if (need_frame) begin
      frames_used++;
      leaf = frames_used;
      page_table[node * ENTRIES + ix[3]] = leaf;
    end
    frame_bytes[(leaf - 1) * FRAME_BYTES + offs] = r.wd;
    writes_stored++;
    return res;
  endfunction

  // Idle length: mostly none, some short, a few long, with calm stretches.
  function automatic int unsigned draw_gap(inout int unsigned calm);
    int unsigned roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random request: mostly hot pages, some with one index changed, some noise.
  function automatic req_t draw_request();
    req_t        r;
    int unsigned roll, lvl;
    roll = $urandom_range(0, 99);
    r.wr = 1'($urandom_range(0, 1));
    r.wd = 8'($urandom);
    r.va = {hot_l0[$urandom_range(0, 2)], hot_l1[$urandom_range(0, 1)],
            hot_l2[$urandom_range(0, 1)], hot_l3[$urandom_range(0, 15)],
            ($urandom_range(0, 1) ? hot_off[$urandom_range(0, 7)] : 12'($urandom))};
    if (roll < 10) begin
      r.va = {16'($urandom), 32'($urandom)};
    end else if (roll < 25) begin
      lvl = $urandom_range(0, 3);
      r.va[47 - 9 * lvl -: 9] = 9'($urandom);
    end
    return r;
  endfunction

  // Offers one request, waits for its handshake and records what must come back.
  task automatic issue_request(input req_t r, input logic typed, input result_t want);
    int unsigned gap;
    result_t     model_res;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.wd, r.va};
    s_axis_tuser  <= r.wr;
    do @(posedge clk_i); while (!s_axis_tready);
    model_res = walk_and_access(r);
    pending_results.push_back(typed ? want : model_res);
  endtask

  // Result side ready: random stalls and one long hold-off.
  initial begin : result_ready
    int unsigned stall;
    logic        hold_done;
    hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!hold_done && results_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      stall = draw_gap(recv_calm);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // Compare each taken result with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_taken <= results_taken + 1;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result data %02h status %0d", $time, m_axis_tdata,
                 m_axis_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.data) begin
          $display("%0t: read_data expected %02h actual %02h", $time, want.data,
                   m_axis_tdata);
          errors++;
        end
        if (m_axis_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, no handshake for %0d cycles", $time, quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Reset, directed table, random traffic, drain and verdict.
  initial begin : stimulus
    int      i;
    result_t none;
    send_calm      = 0;
    read_hits      = 0;
    read_faults    = 0;
    writes_stored  = 0;
    writes_dropped = 0;
    next_node      = 1;
    frames_used    = 0;
    none           = '{data: 8'h00, status: ST_OK};
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;

    hot_l0[0] = 9'h000;
    hot_l0[1] = 9'h1FF;
    hot_l0[2] = 9'($urandom);
    hot_l1[0] = 9'h000;
    hot_l1[1] = 9'($urandom);
    hot_l2[0] = 9'h1FF;
    hot_l2[1] = 9'($urandom);
    for (i = 0; i < 16; i++) hot_l3[i] = 9'($urandom);
    hot_l3[0] = 9'h000;
    hot_l3[1] = 9'h1FF;
    for (i = 0; i < 8; i++) hot_off[i] = 12'($urandom);
    hot_off[0] = 12'h000;
    hot_off[1] = 12'hFFF;

    // Directed requests; typed expectations where the answer is obvious.
    directed_rows = '{
      // Reads before any write find an empty root.
      '{req: '{1'b0, 48'h0000_0000_0000, 8'h00}, typed: 1'b1, want: '{8'h00, ST_FAULT}},
      '{req: '{1'b0, 48'hFFFF_FFFF_FFFF, 8'hFF}, typed: 1'b1, want: '{8'h00, ST_FAULT}},
      // First write builds the whole path and a frame.
      '{req: '{1'b1, 48'h0000_0000_0000, 8'hFF}, typed: 1'b1, want: '{8'h00, ST_OK}},
      '{req: '{1'b0, 48'h0000_0000_0000, 8'h00}, typed: 1'b0, want: none},
      '{req: '{1'b0, 48'h0000_0000_0FFF, 8'h00}, typed: 1'b0, want: none},
      '{req: '{1'b1, 48'h0000_0000_0FFF, 8'h00}, typed: 1'b1, want: '{8'h00, ST_OK}},
      '{req: '{1'b1, 48'hFFFF_FFFF_FFFF, 8'h5A}, typed: 1'b1, want: '{8'h00, ST_OK}},
      '{req: '{1'b0, 48'hFFFF_FFFF_FFFF, 8'h00}, typed: 1'b0, want: none},
      // Faults at each level next to the mapped top page.
      '{req: '{1'b0, 48'hFFFF_FFFF_EFFF, 8'h00}, typed: 1'b1, want: '{8'h00, ST_FAULT}},
      '{req: '{1'b0, 48'hFFFF_FFDF_FFFF, 8'h00}, typed: 1'b1, want: '{8'h00, ST_FAULT}},
      '{req: '{1'b0, 48'hFFBF_FFFF_FFFF, 8'h00}, typed: 1'b1, want: '{8'h00, ST_FAULT}},
      '{req: '{1'b0, 48'h7FFF_FFFF_FFFF, 8'h00}, typed: 1'b1, want: '{8'h00, ST_FAULT}},
      // A sibling page needs only a frame; rewrites need nothing.
      '{req: '{1'b1, 48'hFFFF_FFFF_EFFF, 8'h81}, typed: 1'b1, want: '{8'h00, ST_OK}},
      '{req: '{1'b1, 48'hFFFF_FFFF_F000, 8'h3C}, typed: 1'b1, want: '{8'h00, ST_OK}},
      '{req: '{1'b0, 48'hFFFF_FFFF_F000, 8'h00}, typed: 1'b0, want: none},
      '{req: '{1'b1, 48'hFFFF_FFFF_FFFF, 8'hA5}, typed: 1'b1, want: '{8'h00, ST_OK}},
      '{req: '{1'b0, 48'hFFFF_FFFF_FFFF, 8'h00}, typed: 1'b0, want: none},
      '{req: '{1'b0, 48'hFFFF_FFFF_EFFF, 8'hFF}, typed: 1'b0, want: none},
      // Alternating bit patterns in address and data.
      '{req: '{1'b1, 48'h5555_5555_5555, 8'h55}, typed: 1'b1, want: '{8'h00, ST_OK}},
      '{req: '{1'b0, 48'h5555_5555_5555, 8'hAA}, typed: 1'b0, want: none},
      '{req: '{1'b1, 48'hAAAA_AAAA_AAAA, 8'hAA}, typed: 1'b1, want: '{8'h00, ST_OK}},
      '{req: '{1'b0, 48'hAAAA_AAAA_AAAA, 8'h55}, typed: 1'b0, want: none}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (i = 0; i < DIRECTED_ROWS; i++) begin
      issue_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
    end
    for (i = DIRECTED_ROWS; i < TOTAL_REQUESTS; i++) begin
      issue_request(draw_request(), 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;

    // Let every outstanding result arrive, then watch for strays.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d requests: %0d read hits, %0d read faults, %0d stored writes, %0d dropped",
             TOTAL_REQUESTS, read_hits, read_faults, writes_stored, writes_dropped);
    $display("Pools at the end: %0d of %0d nodes, %0d of %0d frames; %0d mismatches",
             next_node, NODE_COUNT, frames_used, FRAME_COUNT, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
